@@ rtl/ntpcvt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ntpcvt_pkg;

  // NTP seconds at 1970-01-01 00:00:00, low 32 bits (the subtraction wraps mod 2^32)
  localparam logic [31:0] UnixAtNtp     = 32'd2208988800;
  localparam logic [32:0] SecsPerDay    = 33'd86400;
  localparam logic [32:0] SecsPerHour33 = 33'sd3600;
  localparam logic signed [4:0] TzMin   = -5'sd14;
  localparam logic signed [4:0] TzMax   = 5'sd14;

  // floor(x / 675) = (x * Recip675) >> 36 for x < 2^26 (86400 = 128 * 675)
  localparam logic [26:0] Recip675      = 27'd101806633;
  localparam int unsigned Shift675      = 36;
  localparam logic [26:0] Div675        = 27'd675;

  // day offset from 0000-03-01 to 1970-01-01, less the one-day bias of stage one
  localparam logic [19:0] EpochShift    = 20'd719467;
  localparam logic [19:0] Era4Start     = 20'd584388;  // 4 * 146097
  localparam logic [19:0] Era5Start     = 20'd730485;  // 5 * 146097

  // reciprocals of 365 for the 16-bit and 18-bit operands
  localparam logic [16:0] Recip365Lo    = 17'd91930;   // shift 25
  localparam logic [17:0] Recip365Hi    = 18'd183860;  // shift 26
  localparam logic [17:0] CentDay1      = 18'd36524;
  localparam logic [17:0] CentDay2      = 18'd73048;
  localparam logic [17:0] CentDay3      = 18'd109572;
  localparam logic [17:0] EraLastDay    = 18'd146096;

  localparam logic [13:0] Recip225      = 14'd9321;    // shift 21
  localparam logic [10:0] Recip15       = 11'd1093;    // shift 14
  localparam logic [10:0] Recip153      = 11'd1714;    // shift 18
  localparam logic [10:0] Recip100      = 11'd1311;    // shift 17

  // first day of each month of a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // two BCD digits of a value below 100; tens via multiply by 205 >> 11
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    p = 15'(v) * 15'd205;
    t = p[14:11];
    u = v - 7'(t) * 7'd10;
    return {t, u[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/ntp_seconds_to_civil_datetime_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// NTP seconds to local civil date and time in packed BCD. A word is taken on
// every clock edge with start_i high; busy_o is held low, as the pipeline has
// no stall point. Each word comes out as a one-cycle done_o strobe with its
// fields; the receiver cannot hold results, so it must take them in that
// cycle. The pipeline is a chain of constant-reciprocal multipliers
// (days/seconds split, year of era, month, BCD) and compare and subtract
// steps (400-year era, remainders), each followed by a register.
// The time zone is sampled as the word enters;
// write it only while no word is in flight. A time zone outside -14..14 gives
// valid_res_o low with all digits zero.
module ntp_seconds_to_civil_datetime_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tz_we_i,
  input  wire logic [4:0]  timezone_hours_i,
  input  wire logic        start_i,
  input  wire logic [31:0] ntp_seconds_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [15:0]      year_bcd_o,
  output logic [4:0]       month_bcd_o,
  output logic [5:0]       day_bcd_o,
  output logic [5:0]       hour_bcd_o,
  output logic [6:0]       minute_bcd_o,
  output logic [6:0]       second_bcd_o,
  output logic             valid_res_o
);

  localparam int unsigned Depth = 11;

  logic [4:0]       tz_q;
  logic [Depth-1:0] v_q, v_d;
  logic [Depth-2:0] ok_q;

  // stage registers
  logic [32:0] loc1_q;
  logic [16:0] dq2_q;
  logic [25:0] x2_q;
  logic [6:0]  lo2_q;
  logic [16:0] sod3_q;
  logic [17:0] doe3_q;
  logic        era3_q;
  logic [17:0] n4_q, doe4_q;
  logic        era4_q;
  logic [4:0]  hour4_q;
  logic [16:0] sod4_q;
  logic [8:0]  yoe5_q;
  logic [17:0] doe5_q;
  logic        era5_q;
  logic [4:0]  hour5_q;
  logic [11:0] rs5_q;
  logic [8:0]  doy6_q, yoe6_q;
  logic        era6_q;
  logic [4:0]  hour6_q;
  logic [5:0]  min6_q;
  logic [11:0] rs6_q;
  logic [3:0]  mp7_q;
  logic [8:0]  doy7_q, yoe7_q;
  logic        era7_q;
  logic [4:0]  hour7_q;
  logic [5:0]  min7_q, sec7_q;
  logic [11:0] year8_q;
  logic [3:0]  month8_q;
  logic [4:0]  day8_q, hour8_q;
  logic [5:0]  min8_q, sec8_q;
  logic [11:0] year9_q;
  logic [5:0]  yhi9_q;
  logic [7:0]  mo9_q, dy9_q, hr9_q, mi9_q, se9_q;
  logic [5:0]  yhi10_q;
  logic [6:0]  ylo10_q;
  logic [7:0]  mo10_q, dy10_q, hr10_q, mi10_q, se10_q;
  logic [15:0] year_bcd_q;
  logic [4:0]  month_bcd_q;
  logic [5:0]  day_bcd_q, hour_bcd_q;
  logic [6:0]  minute_bcd_q, second_bcd_q;
  logic        valid_res_q;

  // combinational per stage
  logic        tz_ok;
  logic [31:0] unix32;
  logic [32:0] tz_off, loc1_d;
  logic [52:0] dq_prod;
  logic [26:0] dq675, rem_full;
  logic [19:0] z3, doe_full;
  logic        era3_d;
  logic [32:0] a_prod;
  logic [7:0]  a4;
  logic [2:0]  b4;
  logic [17:0] n4_d;
  logic [26:0] hr_prod;
  logic [35:0] y_prod;
  logic [16:0] hr3600, rs_full;
  logic [1:0]  c100;
  logic [17:0] yd, doy_full;
  logic [20:0] mi_prod;
  logic [10:0] mp_num;
  logic [21:0] mp_prod;
  logic [11:0] sec_full;
  logic [8:0]  day_full;
  logic [3:0]  month8_d;
  logic [11:0] year8_d;
  logic [22:0] yhi_prod;
  logic [11:0] ylo_full;

  assign busy_o = 1'b0;
  assign tz_ok  = ($signed(tz_q) >= ntpcvt_pkg::TzMin) && ($signed(tz_q) <= ntpcvt_pkg::TzMax);

  // stage 1: era fold (wrapping subtract), zone offset, one-day bias keeps it positive
  always_comb begin
    unix32 = ntp_seconds_i - ntpcvt_pkg::UnixAtNtp;
    tz_off = 33'($signed({{28{tz_q[4]}}, tz_q}) * $signed(ntpcvt_pkg::SecsPerHour33));
    loc1_d = {1'b0, unix32} + ntpcvt_pkg::SecsPerDay + tz_off;
  end

  // stage 2: day count = (loc >> 7) / 675
  assign dq_prod = 53'(loc1_q[32:7]) * 53'(ntpcvt_pkg::Recip675);

  // stage 3: second of day, then era and day of era by compare and subtract
  always_comb begin
    dq675    = 27'(dq2_q) * ntpcvt_pkg::Div675;
    rem_full = 27'(x2_q) - dq675;
    z3       = 20'(dq2_q) + ntpcvt_pkg::EpochShift;
    era3_d   = (z3 >= ntpcvt_pkg::Era5Start);
    doe_full = z3 - (era3_d ? ntpcvt_pkg::Era5Start : ntpcvt_pkg::Era4Start);
  end

  // stage 4: leap corrections of the year-of-era numerator; hour
  always_comb begin
    a_prod  = 33'(doe3_q[17:2]) * 33'(ntpcvt_pkg::Recip365Lo);
    a4      = a_prod[32:25];
    b4      = 3'(doe3_q >= ntpcvt_pkg::CentDay1) + 3'(doe3_q >= ntpcvt_pkg::CentDay2)
            + 3'(doe3_q >= ntpcvt_pkg::CentDay3) + 3'(doe3_q >= ntpcvt_pkg::EraLastDay);
    n4_d    = doe3_q - 18'(a4) + 18'(b4) - 18'(doe3_q == ntpcvt_pkg::EraLastDay);
    hr_prod = 27'(sod3_q[16:4]) * 27'(ntpcvt_pkg::Recip225);
  end

  // stage 5: year of era; seconds within the hour
  always_comb begin
    y_prod  = 36'(n4_q) * 36'(ntpcvt_pkg::Recip365Hi);
    hr3600  = 17'(hour4_q) * 17'd3600;
    rs_full = sod4_q - hr3600;
  end

  // stage 6: day of year; minute
  always_comb begin
    c100     = 2'(yoe5_q >= 9'd100) + 2'(yoe5_q >= 9'd200) + 2'(yoe5_q >= 9'd300);
    yd       = 18'(yoe5_q) * 18'd365 + 18'(yoe5_q[8:2]) - 18'(c100);
    doy_full = doe5_q - yd;
    mi_prod  = 21'(rs5_q[11:2]) * 21'(ntpcvt_pkg::Recip15);
  end

  // stage 7: March-based month; second
  always_comb begin
    mp_num   = 11'(doy6_q) * 11'd5 + 11'd2;
    mp_prod  = 22'(mp_num) * 22'(ntpcvt_pkg::Recip153);
    sec_full = rs6_q - 12'(min6_q) * 12'd60;
  end

  // stage 8: day, calendar month and year
  always_comb begin
    day_full = doy7_q - ntpcvt_pkg::month_start(mp7_q) + 9'd1;
    month8_d = (mp7_q < 4'd10) ? (mp7_q + 4'd3) : (mp7_q - 4'd9);
    year8_d  = 12'(yoe7_q) + (era7_q ? 12'd2000 : 12'd1600) + 12'(month8_d <= 4'd2);
  end

  // stages 9 and 10: split year into centuries and rest
  assign yhi_prod = 23'(year8_q) * 23'(ntpcvt_pkg::Recip100);
  assign ylo_full = year9_q - 12'(yhi9_q) * 12'd100;

  // valid bits and time zone register
  assign v_d = {v_q[Depth-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_q <= '0;
      v_q  <= '0;
    end else begin
      if (tz_we_i) begin
        tz_q <= timezone_hours_i;
      end
      v_q <= v_d;
    end
  end

  // datapath; words march forward each cycle
  always_ff @(posedge clk_i) begin
    loc1_q   <= loc1_d;
    ok_q     <= {ok_q[Depth-3:0], tz_ok};
    dq2_q    <= dq_prod[ntpcvt_pkg::Shift675 +: 17];
    x2_q     <= loc1_q[32:7];
    lo2_q    <= loc1_q[6:0];
    sod3_q   <= {rem_full[9:0], lo2_q};
    doe3_q   <= doe_full[17:0];
    era3_q   <= era3_d;
    n4_q     <= n4_d;
    doe4_q   <= doe3_q;
    era4_q   <= era3_q;
    hour4_q  <= hr_prod[25:21];
    sod4_q   <= sod3_q;
    yoe5_q   <= y_prod[34:26];
    doe5_q   <= doe4_q;
    era5_q   <= era4_q;
    hour5_q  <= hour4_q;
    rs5_q    <= rs_full[11:0];
    doy6_q   <= doy_full[8:0];
    yoe6_q   <= yoe5_q;
    era6_q   <= era5_q;
    hour6_q  <= hour5_q;
    min6_q   <= mi_prod[19:14];
    rs6_q    <= rs5_q;
    mp7_q    <= mp_prod[21:18];
    doy7_q   <= doy6_q;
    yoe7_q   <= yoe6_q;
    era7_q   <= era6_q;
    hour7_q  <= hour6_q;
    min7_q   <= min6_q;
    sec7_q   <= sec_full[5:0];
    year8_q  <= year8_d;
    month8_q <= month8_d;
    day8_q   <= day_full[4:0];
    hour8_q  <= hour7_q;
    min8_q   <= min7_q;
    sec8_q   <= sec7_q;
    year9_q  <= year8_q;
    yhi9_q   <= yhi_prod[22:17];
    mo9_q    <= ntpcvt_pkg::bcd2(7'(month8_q));
    dy9_q    <= ntpcvt_pkg::bcd2(7'(day8_q));
    hr9_q    <= ntpcvt_pkg::bcd2(7'(hour8_q));
    mi9_q    <= ntpcvt_pkg::bcd2(7'(min8_q));
    se9_q    <= ntpcvt_pkg::bcd2(7'(sec8_q));
    yhi10_q  <= yhi9_q;
    ylo10_q  <= ylo_full[6:0];
    mo10_q   <= mo9_q;
    dy10_q   <= dy9_q;
    hr10_q   <= hr9_q;
    mi10_q   <= mi9_q;
    se10_q   <= se9_q;
  end

  // result register, loaded only for a live word and zeroed for a bad zone
  // (year always lies within 1969..2106 once the zone is legal)
  always_ff @(posedge clk_i) begin
    if (v_q[Depth-2]) begin
      if (ok_q[Depth-2]) begin
        year_bcd_q   <= {ntpcvt_pkg::bcd2(7'(yhi10_q)), ntpcvt_pkg::bcd2(ylo10_q)};
        month_bcd_q  <= mo10_q[4:0];
        day_bcd_q    <= dy10_q[5:0];
        hour_bcd_q   <= hr10_q[5:0];
        minute_bcd_q <= mi10_q[6:0];
        second_bcd_q <= se10_q[6:0];
        valid_res_q  <= 1'b1;
      end else begin
        year_bcd_q   <= '0;
        month_bcd_q  <= '0;
        day_bcd_q    <= '0;
        hour_bcd_q   <= '0;
        minute_bcd_q <= '0;
        second_bcd_q <= '0;
        valid_res_q  <= 1'b0;
      end
    end
  end

  assign done_o       = v_q[Depth-1];
  assign year_bcd_o   = year_bcd_q;
  assign month_bcd_o  = month_bcd_q;
  assign day_bcd_o    = day_bcd_q;
  assign hour_bcd_o   = hour_bcd_q;
  assign minute_bcd_o = minute_bcd_q;
  assign second_bcd_o = second_bcd_q;
  assign valid_res_o  = valid_res_q;

  // every strobe comes from a word taken a fixed latency earlier
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Depth))
    else $error("result strobe without matching start");

  // a valid result names a month of 1..12, a non-zero day and an hour up to 23
  a_valid_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && valid_res_o) |-> (month_bcd_o != 5'd0 && day_bcd_o != 6'd0 &&
                                 month_bcd_o <= 5'h12 && hour_bcd_o <= 6'h23))
    else $error("valid result out of calendar range");

  // an invalid result carries zero year, month, day and second digits
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !valid_res_o) |-> (year_bcd_o == 16'd0 && month_bcd_o == 5'd0 &&
                                  day_bcd_o == 6'd0 && second_bcd_o == 7'd0))
    else $error("invalid result with non-zero digits");

endmodule

`default_nettype wire

@@ tb/ntp_seconds_to_civil_datetime_checker.sv @@
`timescale 1ns / 1ps

// Watches the word and result channels of the NTP-to-civil-date unit, predicts
// each result from the accepted word and the current time zone, and compares.
module ntp_seconds_to_civil_datetime_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tz_we_i,
  input  wire logic [4:0]  timezone_hours_i,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [31:0] ntp_seconds_i,
  input  wire logic        done_i,
  input  wire logic [15:0] year_bcd_i,
  input  wire logic [4:0]  month_bcd_i,
  input  wire logic [5:0]  day_bcd_i,
  input  wire logic [5:0]  hour_bcd_i,
  input  wire logic [6:0]  minute_bcd_i,
  input  wire logic [6:0]  second_bcd_i,
  input  wire logic        valid_res_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  localparam longint NtpUnixEpoch = 64'd2208988800;
  localparam longint NtpEraLen    = 64'h1_0000_0000;
  localparam longint SecsPerDay   = 86400;
  localparam longint SecsPerHour  = 3600;
  localparam longint MaxYear      = 9999;
  localparam int     ReportLimit  = 10;
  localparam logic signed [4:0] TzLow  = -5'sd14;
  localparam logic signed [4:0] TzHigh = 5'sd14;

  typedef struct packed {
    logic [15:0] year;
    logic [4:0]  month;
    logic [5:0]  day;
    logic [5:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic        valid;
  } date_word_t;

  logic signed [4:0] tz_q;
  date_word_t        expected_dates[$];
  date_word_t        got;
  date_word_t        want;
  int                mismatches;

  // two BCD digits of a value below 100
  function automatic logic [7:0] to_bcd2(input longint v);
    return {4'(v / 10 % 10), 4'(v % 10)};
  endfunction

  // local civil date and time for one NTP seconds word
  function automatic date_word_t civil_from_ntp(input logic [31:0] ntp,
                                                input logic signed [4:0] tz);
    date_word_t r;
    longint ext, lsec, days, sod, z, era, doe, yoe, doy, mp, yr, mo, dy;
    r = '0;
    if (tz < TzLow || tz > TzHigh) return r;
    ext = longint'({32'd0, ntp});
    // 1970..2106 window: early values belong to the next era
    if (ext < NtpUnixEpoch) ext = ext + NtpEraLen;
    lsec = ext - NtpUnixEpoch + longint'(tz) * SecsPerHour;
    // floored split into days and second of day
    days = lsec / SecsPerDay;
    sod  = lsec % SecsPerDay;
    if (sod < 0) begin
      sod  = sod + SecsPerDay;
      days = days - 1;
    end
    // civil from days, years starting on 1 March, 400-year eras
    z   = days + 719468;
    era = ((z >= 0) ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    dy  = doy - (153 * mp + 2) / 5 + 1;
    mo  = (mp < 10) ? mp + 3 : mp - 9;
    yr  = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
    if (yr < 0 || yr > MaxYear) return r;
    r.year   = {4'(yr / 1000 % 10), 4'(yr / 100 % 10), 4'(yr / 10 % 10), 4'(yr % 10)};
    r.month  = 5'(to_bcd2(mo));
    r.day    = 6'(to_bcd2(dy));
    r.hour   = 6'(to_bcd2(sod / SecsPerHour));
    r.minute = 7'(to_bcd2(sod / 60 % 60));
    r.second = 7'(to_bcd2(sod % 60));
    r.valid  = 1'b1;
    return r;
  endfunction

  // compare results, then queue a prediction for each accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_q <= '0;
      expected_dates.delete();
      mismatches   = 0;
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (done_i) begin
        got = '{year_bcd_i, month_bcd_i, day_bcd_i, hour_bcd_i, minute_bcd_i,
                second_bcd_i, valid_res_i};
        if (expected_dates.size() == 0) begin
          fail_count_o++;
          if (mismatches < ReportLimit)
            $display("[%0t] result with nothing outstanding: %h-%h-%h %h:%h:%h v=%b",
                     $realtime, got.year, got.month, got.day, got.hour, got.minute,
                     got.second, got.valid);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          checked_o++;
          if (got !== want) begin
            fail_count_o++;
            if (mismatches < ReportLimit)
              $display({"[%0t] mismatch: expected %h-%h-%h %h:%h:%h v=%b,",
                        " got %h-%h-%h %h:%h:%h v=%b"},
                       $realtime, want.year, want.month, want.day, want.hour,
                       want.minute, want.second, want.valid, got.year, got.month,
                       got.day, got.hour, got.minute, got.second, got.valid);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i)
        expected_dates.push_back(civil_from_ntp(ntp_seconds_i, tz_q));
      if (tz_we_i) tz_q <= timezone_hours_i;
      pending_o = expected_dates.size();
    end
  end

endmodule

@@ tb/ntp_seconds_to_civil_datetime_unit_tb.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the NTP-to-civil-date unit; checking lives in the
// checker instance beside the DUT.
module ntp_seconds_to_civil_datetime_unit_tb;

  localparam int Latency      = 11;
  localparam int CycleLimit   = 200000;
  localparam int WordsPerZone = 138;
  localparam int RandomZones  = 7;
  localparam logic [31:0] EpochWord = 32'd2208988800;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        tz_we_r = 1'b0;
  logic [4:0]  tz_r = '0;
  logic        start_r = 1'b0;
  logic [31:0] ntp_r = '0;

  logic        busy_o;
  logic        done_o;
  logic [15:0] year_bcd_o;
  logic [4:0]  month_bcd_o;
  logic [5:0]  day_bcd_o;
  logic [5:0]  hour_bcd_o;
  logic [6:0]  minute_bcd_o;
  logic [6:0]  second_bcd_o;
  logic        valid_res_o;

  int fail_count;
  int pending;
  int checked;
  int cycle_cnt = 0;
  int words_sent = 0;
  int zones_seen = 1;

  // words that hit calendar corners: era wrap, epoch, leap days, century
  logic [31:0] corner_words[] = '{
    32'h0000_0000, 32'hFFFF_FFFF, EpochWord, EpochWord - 32'd1, EpochWord + 32'd1,
    32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
    32'd3160771200, 32'd3160857599, 32'd3160857600,
    32'd2021563903, 32'd2021563904, 32'd3155673599, 32'd3155673600,
    32'd2214086400, 32'd2277158400
  };

  // legal extremes first, then the three out-of-range codes, then back to UTC
  logic [4:0] zone_plan[] = '{5'd14, 5'b10010, 5'd15, 5'b10000, 5'b10001, 5'd0};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ntp_seconds_to_civil_datetime_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tz_we_i          (tz_we_r),
    .timezone_hours_i (tz_r),
    .start_i          (start_r),
    .ntp_seconds_i    (ntp_r),
    .busy_o           (busy_o),
    .done_o           (done_o),
    .year_bcd_o       (year_bcd_o),
    .month_bcd_o      (month_bcd_o),
    .day_bcd_o        (day_bcd_o),
    .hour_bcd_o       (hour_bcd_o),
    .minute_bcd_o     (minute_bcd_o),
    .second_bcd_o     (second_bcd_o),
    .valid_res_o      (valid_res_o)
  );

  ntp_seconds_to_civil_datetime_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tz_we_i          (tz_we_r),
    .timezone_hours_i (tz_r),
    .start_i          (start_r),
    .busy_i           (busy_o),
    .ntp_seconds_i    (ntp_r),
    .done_i           (done_o),
    .year_bcd_i       (year_bcd_o),
    .month_bcd_i      (month_bcd_o),
    .day_bcd_i        (day_bcd_o),
    .hour_bcd_i       (hour_bcd_o),
    .minute_bcd_i     (minute_bcd_o),
    .second_bcd_i     (second_bcd_o),
    .valid_res_i      (valid_res_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // random word, weighted towards era, epoch and midnight boundaries
  function automatic logic [31:0] pick_word();
    int unsigned      sel;
    longint unsigned  day;
    longint unsigned  off;
    logic [31:0]      w;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      w = $urandom();
    end else if (sel < 45) begin
      w = EpochWord + 32'($urandom_range(0, 200000)) - 32'd100000;
    end else if (sel < 60) begin
      if ($urandom_range(0, 1)) w = 32'($urandom_range(0, 100000));
      else w = 32'hFFFF_FFFF - 32'($urandom_range(0, 100000));
    end else begin
      day = $urandom_range(0, 49710);
      case ($urandom_range(0, 4))
        0: begin
          off = 0;
        end
        1: begin
          off = 86399;
        end
        2: begin
          off = $urandom_range(0, 3599);
        end
        3: begin
          off = 86399 - $urandom_range(0, 3599);
        end
        default: begin
          off = $urandom_range(0, 86399);
        end
      endcase
      w = 32'(day * 86400 + off + 64'd2208988800);
    end
    return w;
  endfunction

  // present one word and hold it until the unit takes it
  task automatic drive_word(input logic [31:0] w);
    @(negedge clk_i);
    start_r <= 1'b1;
    ntp_r   <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    words_sent++;
  endtask

  // sender gap
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_r <= 1'b0;
    end
  endtask

  // random words in bursts with random gaps between them
  task automatic send_bursts(input int n);
    int sent;
    int burst;
    int k;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < n; k++) begin
        drive_word(pick_word());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 15));
    end
    hold_off(1);
  endtask

  // time zone write once every outstanding word has come back
  task automatic write_zone(input logic [4:0] tz);
    do @(negedge clk_i); while (pending != 0);
    repeat (Latency + 2) @(negedge clk_i);
    tz_we_r <= 1'b1;
    tz_r    <= tz;
    @(negedge clk_i);
    tz_we_r <= 1'b0;
    zones_seen++;
  endtask

  // run-length guard
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int i;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // corner words under the reset time zone, back to back
    for (i = 0; i < corner_words.size(); i++) drive_word(corner_words[i]);
    hold_off(1);
    send_bursts(WordsPerZone);

    // planned and random time zones, each opening on the epoch and wrap words
    for (i = 0; i < zone_plan.size() + RandomZones; i++) begin
      if (i < zone_plan.size()) write_zone(zone_plan[i]);
      else write_zone(5'($urandom_range(0, 31)));
      drive_word(EpochWord);
      drive_word(EpochWord - 32'd1);
      hold_off(1);
      send_bursts(WordsPerZone);
    end

    // drain
    do @(negedge clk_i); while (pending != 0);
    repeat (Latency * 4) @(negedge clk_i);

    $display("Converted %0d NTP words across %0d time zone settings, %0d results compared.",
             words_sent, zones_seen, checked);
    $display("Zones covered +14 and -14 hours plus the out-of-range codes; %0d failures.",
             fail_count + pending);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
